### rtl/event_log_record_decoder_defines.svh
// ---------------------------------------------------------------------------
// Event log record decoder assertion macros
// Concurrent assertion helpers, empty when SYNTH is defined.
// ---------------------------------------------------------------------------
`ifndef EVENT_LOG_RECORD_DECODER_DEFINES_SVH
`define EVENT_LOG_RECORD_DECODER_DEFINES_SVH

`ifndef SYNTH
`define ELRD_ASSERT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define ELRD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ELRD_ASSERT(label, clk, rst_n, ante, cons)
`define ELRD_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

### rtl/elrd_pkg.sv
// ---------------------------------------------------------------------------
// Event log record decoder package
// Token kinds, field codes, decoder phases, record type and class codes, length prefixes and defaults.
// ---------------------------------------------------------------------------
package elrd_pkg;

    localparam int MAX_PARAMS_DEF = 256;

    typedef enum logic [2:0] {
        KIND_INT     = 3'd0,
        KIND_STR_LEN = 3'd1,
        KIND_STR_BYTE = 3'd2,
        KIND_NULL    = 3'd3,
        KIND_ERR     = 3'd4
    } kind_t;

    localparam logic [4:0] FLD_CLASS       = 5'd0;
    localparam logic [4:0] FLD_HOST        = 5'd5;
    localparam logic [4:0] FLD_END         = 5'd8;
    localparam logic [4:0] FLD_QUERY       = 5'd14;
    localparam logic [4:0] FLD_PARAM_COUNT = 5'd15;
    localparam logic [4:0] FLD_PARAM_TYPE  = 5'd16;
    localparam logic [4:0] FLD_PARAM_VALUE = 5'd17;

    localparam logic [4:0] PH_SKIP   = 5'd0;
    localparam logic [4:0] PH_TYPE   = 5'd1;
    localparam logic [4:0] PH_BITMAP = 5'd19;

    localparam logic [7:0] TYPE_EXECUTE  = 8'd16;
    localparam logic [7:0] TYPE_PREPARE  = 8'd17;
    localparam logic [7:0] TYPE_METADATA = 8'd18;

    localparam logic [1:0] CLS_QUERY    = 2'd0;
    localparam logic [1:0] CLS_EXECUTE  = 2'd1;
    localparam logic [1:0] CLS_PREPARE  = 2'd2;
    localparam logic [1:0] CLS_METADATA = 2'd3;

    localparam logic [7:0] LENC_2 = 8'hfc;
    localparam logic [7:0] LENC_3 = 8'hfd;
    localparam logic [7:0] LENC_8 = 8'hfe;
    localparam logic [7:0] LENC_MIN = 8'd251;

endpackage

### rtl/elrd_in_if.sv
// ---------------------------------------------------------------------------
// Event log record decoder input channel
// Valid/ready channel carrying one stream byte per word.
// ---------------------------------------------------------------------------
interface elrd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink (input valid, input data_byte, output ready);
endinterface

### rtl/elrd_out_if.sv
// ---------------------------------------------------------------------------
// Event log record decoder output channel
// Valid/ready channel carrying one decoded token per word.
// ---------------------------------------------------------------------------
interface elrd_out_if;
    logic        valid;
    logic        ready;
    logic [4:0]  field_code;
    logic [2:0]  token_kind;
    logic [63:0] token_value;
    logic [7:0]  param_index;
    logic        string_last;
    logic        record_end;

    modport source (output valid, output field_code, output token_kind, output token_value,
                    output param_index, output string_last, output record_end, input ready);
    modport sink (input valid, input field_code, input token_kind, input token_value,
                  input param_index, input string_last, input record_end, output ready);
endinterface

### rtl/event_log_record_decoder.sv
// ---------------------------------------------------------------------------
// Event log record decoder
// Turns an event log byte stream into field, length and string byte tokens.
// ---------------------------------------------------------------------------
// One byte is taken per clock and yields zero or one token in the next cycle,
// held in an output register; stream.ready is high whenever that register is
// empty or being drained, so a steady stream runs at one byte per cycle. The
// null bitmap lives in a memory of one row per eight parameters, read into a
// register ahead of use; it needs no clearing pass after reset. After an error
// token the block drops all bytes until reset.
`include "event_log_record_decoder_defines.svh"

module event_log_record_decoder
    import elrd_pkg::*;
#(
    parameter int MAX_PARAMS = MAX_PARAMS_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    elrd_in_if.sink    stream,
    elrd_out_if.source token
);

    localparam int CW   = $clog2(MAX_PARAMS + 1);
    localparam int ROWS = (MAX_PARAMS + 7) / 8;
    localparam int RAW  = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int BLW  = $clog2(ROWS + 1);

    logic [4:0]    phase_reg, phase_next;
    logic [3:0]    skip_reg, skip_next;
    logic [1:0]    cls_reg, cls_next;
    logic [3:0]    ibl_reg, ibl_next;
    logic [2:0]    pos_reg, pos_next;
    logic [63:0]   acc_reg, acc_next;
    logic [63:0]   sleft_reg, sleft_next;
    logic          host_reg, host_next;
    logic [CW-1:0] total_reg, total_next;
    logic [CW-1:0] done_reg, done_next;
    logic [BLW-1:0] bml_reg, bml_next;
    logic          halted_reg, halted_next;
    logic          instr_reg, instr_next;

    logic          out_valid_reg;
    logic [4:0]    f_reg;
    kind_t         k_reg;
    logic [63:0]   v_reg;
    logic [7:0]    p_reg;
    logic          last_reg;
    logic          end_reg;

    logic [7:0]    mem [ROWS];
    logic [7:0]    rd_row_reg;
    logic          we;
    logic [RAW-1:0] wa;
    logic [RAW-1:0] ra;
    logic          ra_ok;

    logic          fire;
    logic          emit;
    logic [4:0]    e_f;
    kind_t         e_k;
    logic [63:0]   e_v;
    logic [7:0]    e_p;
    logic          e_last;
    logic          e_end;
    logic          do_adv;
    logic [4:0]    adv_f;
    logic          do_np;
    logic          end_rec;
    logic [4:0]    f;
    logic [7:0]    b;
    logic [63:0]   v;
    logic          have_v;
    logic          is_null;
    logic [CW:0]   rows_total;
    logic [CW:0]   done_inc;
    logic [BLW-1:0] wrow;

    assign stream.ready = !out_valid_reg || token.ready;
    assign fire = stream.valid && stream.ready;
    assign b = stream.data_byte;
    assign f = phase_reg - 5'd1;
    assign is_null = rd_row_reg[done_reg[2:0]];
    assign rows_total = ({1'b0, total_reg} + (CW + 1)'(7)) >> 3;
    assign wrow = BLW'(rows_total) - bml_reg;
    assign wa = RAW'(wrow);
    assign done_inc = {1'b0, done_reg} + (CW + 1)'(1);
    assign ra = RAW'(done_next >> 3);
    assign ra_ok = (done_next >> 3) < CW'(ROWS);

    always_comb
    begin
        phase_next  = phase_reg;
        skip_next   = skip_reg;
        cls_next    = cls_reg;
        ibl_next    = ibl_reg;
        pos_next    = pos_reg;
        acc_next    = acc_reg;
        sleft_next  = sleft_reg;
        host_next   = host_reg;
        total_next  = total_reg;
        done_next   = done_reg;
        bml_next    = bml_reg;
        halted_next = halted_reg;
        instr_next  = instr_reg;
        emit   = 1'b0;
        e_f    = f;
        e_k    = KIND_INT;
        e_v    = 64'(b);
        e_p    = (f >= FLD_PARAM_TYPE) ? 8'(done_reg) : 8'd0;
        e_last = 1'b0;
        e_end  = 1'b0;
        do_adv = 1'b0;
        adv_f  = f;
        do_np  = 1'b0;
        end_rec = 1'b0;
        have_v = 1'b0;
        v      = 64'd0;
        we     = 1'b0;

        if (fire && !halted_reg)
        begin
            if (phase_reg == PH_SKIP)
            begin
                if (skip_reg != 4'd0)
                    skip_next = skip_reg - 4'd1;
                if (skip_next == 4'd0)
                    phase_next = PH_TYPE;
            end
            else if (phase_reg == PH_TYPE)
            begin
                case (b)
                    TYPE_EXECUTE:  cls_next = CLS_EXECUTE;
                    TYPE_PREPARE:  cls_next = CLS_PREPARE;
                    TYPE_METADATA: cls_next = CLS_METADATA;
                    default:       cls_next = CLS_QUERY;
                endcase
                host_next  = 1'b0;
                total_next = '0;
                done_next  = '0;
                instr_next = 1'b0;
                ibl_next   = 4'd0;
                pos_next   = 3'd0;
                phase_next = 5'd2;
                emit = 1'b1;
                e_f  = FLD_CLASS;
                e_v  = 64'(cls_next);
                e_p  = 8'd0;
            end
            else if (phase_reg == PH_BITMAP)
            begin
                we = 1'b1;
                if (bml_reg != '0)
                    bml_next = bml_reg - BLW'(1);
                if (bml_next == '0)
                begin
                    done_next  = '0;
                    phase_next = 5'd17;
                    pos_next   = 3'd0;
                end
            end
            else if (phase_reg < 5'd2 || phase_reg > 5'd18)
            begin
                end_rec = 1'b1;
            end
            else if (f == FLD_PARAM_TYPE)
            begin
                if (pos_reg == 3'd0)
                begin
                    acc_next = 64'(b);
                    pos_next = 3'd1;
                    if (is_null)
                    begin
                        emit = 1'b1;
                        e_f  = FLD_PARAM_VALUE;
                        e_k  = KIND_NULL;
                        e_v  = 64'd0;
                    end
                end
                else
                begin
                    pos_next = 3'd0;
                    emit = 1'b1;
                    e_v  = acc_reg | (64'(b) << 8);
                    if (is_null)
                        do_np = 1'b1;
                    else
                        do_adv = 1'b1;
                end
            end
            else if (instr_reg)
            begin
                sleft_next = sleft_reg - 64'd1;
                emit = 1'b1;
                e_k  = KIND_STR_BYTE;
                if (sleft_next == 64'd0)
                begin
                    e_last = 1'b1;
                    instr_next = 1'b0;
                    do_adv = 1'b1;
                end
            end
            else if (ibl_reg == 4'd0)
            begin
                if (b < LENC_MIN)
                begin
                    have_v = 1'b1;
                    v = 64'(b);
                end
                else if (b == LENC_2 || b == LENC_3 || b == LENC_8)
                begin
                    ibl_next = (b == LENC_2) ? 4'd2 : (b == LENC_3) ? 4'd3 : 4'd8;
                    acc_next = 64'd0;
                    pos_next = 3'd0;
                end
                else
                begin
                    halted_next = 1'b1;
                    emit  = 1'b1;
                    e_k   = KIND_ERR;
                    e_end = 1'b1;
                end
            end
            else
            begin
                acc_next = acc_reg | (64'(b) << {pos_reg, 3'b000});
                pos_next = pos_reg + 3'd1;
                ibl_next = ibl_reg - 4'd1;
                if (ibl_next == 4'd0)
                begin
                    have_v = 1'b1;
                    v = acc_next;
                    pos_next = 3'd0;
                end
            end

            if (have_v)
            begin
                emit = 1'b1;
                e_v  = v;
                if (f == 5'd2 || f == 5'd3 || f == 5'd4 || f == 5'd6 || f == FLD_QUERY ||
                    f == FLD_PARAM_VALUE)
                begin
                    e_k = KIND_STR_LEN;
                    if (v == 64'd0)
                        do_adv = 1'b1;
                    else
                    begin
                        instr_next = 1'b1;
                        sleft_next = v;
                    end
                end
                else if (f == FLD_PARAM_COUNT && v > 64'(MAX_PARAMS))
                begin
                    halted_next = 1'b1;
                    e_k   = KIND_ERR;
                    e_p   = 8'd0;
                    e_end = 1'b1;
                end
                else
                begin
                    if (f == FLD_HOST)
                        host_next = (v != '1);
                    if (f == FLD_PARAM_COUNT)
                        total_next = CW'(v);
                    do_adv = 1'b1;
                end
            end

            if (do_adv)
            begin
                case (adv_f)
                    FLD_HOST:
                        phase_next = host_next ? 5'd7 : 5'd8;
                    FLD_END:
                        phase_next = (cls_reg == CLS_EXECUTE || cls_reg == CLS_PREPARE) ?
                                     5'd10 : 5'd11;
                    FLD_QUERY:
                        if (cls_reg == CLS_EXECUTE)
                            phase_next = 5'd16;
                        else
                            end_rec = 1'b1;
                    FLD_PARAM_COUNT:
                        if (total_next == '0)
                            end_rec = 1'b1;
                        else
                        begin
                            bml_next   = BLW'(({1'b0, total_next} + (CW + 1)'(7)) >> 3);
                            done_next  = '0;
                            phase_next = PH_BITMAP;
                        end
                    FLD_PARAM_TYPE:
                        phase_next = 5'd18;
                    FLD_PARAM_VALUE:
                        do_np = 1'b1;
                    default:
                        phase_next = adv_f + 5'd2;
                endcase
            end

            if (do_np)
            begin
                done_next = CW'(done_inc);
                if (done_inc >= {1'b0, total_reg})
                    end_rec = 1'b1;
                else
                begin
                    phase_next = 5'd17;
                    pos_next   = 3'd0;
                end
            end

            if (end_rec)
            begin
                phase_next = PH_SKIP;
                skip_next  = 4'd8;
                instr_next = 1'b0;
                ibl_next   = 4'd0;
                pos_next   = 3'd0;
                e_end      = 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
            mem[wa] <= b;
        if (we && wa == ra)
            rd_row_reg <= b;
        else if (ra_ok)
            rd_row_reg <= mem[ra];
        else
            rd_row_reg <= 8'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_SKIP;
            skip_reg   <= 4'd8;
            cls_reg    <= CLS_QUERY;
            ibl_reg    <= 4'd0;
            pos_reg    <= 3'd0;
            acc_reg    <= 64'd0;
            sleft_reg  <= 64'd0;
            host_reg   <= 1'b0;
            total_reg  <= '0;
            done_reg   <= '0;
            bml_reg    <= '0;
            halted_reg <= 1'b0;
            instr_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg  <= phase_next;
            skip_reg   <= skip_next;
            cls_reg    <= cls_next;
            ibl_reg    <= ibl_next;
            pos_reg    <= pos_next;
            acc_reg    <= acc_next;
            sleft_reg  <= sleft_next;
            host_reg   <= host_next;
            total_reg  <= total_next;
            done_reg   <= done_next;
            bml_reg    <= bml_next;
            halted_reg <= halted_next;
            instr_reg  <= instr_next;
            if (emit)
                out_valid_reg <= 1'b1;
            else if (token.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            f_reg    <= e_f;
            k_reg    <= e_k;
            v_reg    <= e_v;
            p_reg    <= e_p;
            last_reg <= e_last;
            end_reg  <= e_end;
        end
    end

    assign token.valid       = out_valid_reg;
    assign token.field_code  = f_reg;
    assign token.token_kind  = k_reg;
    assign token.token_value = v_reg;
    assign token.param_index = p_reg;
    assign token.string_last = last_reg;
    assign token.record_end  = end_reg;

    `ELRD_ASSERT(a_err_ends, clk, rst_n, out_valid_reg && k_reg == KIND_ERR, end_reg)
    `ELRD_ASSERT(a_last_is_byte, clk, rst_n, out_valid_reg && last_reg, k_reg == KIND_STR_BYTE)
    `ELRD_ASSERT_NEXT(a_halt_quiet, clk, rst_n, halted_reg && token.ready, !out_valid_reg)

endmodule

### tb/tb_event_log_record_decoder.sv
// ---------------------------------------------------------------------------
// Event log record decoder testbench
// Sends query, prepare, metadata and execute records as bytes through the
// stream channel and checks each token against a cycle-free decoder model.
// Ends with one halting error (bad integer prefix or too many parameters).
// ---------------------------------------------------------------------------
module tb_event_log_record_decoder;
    import elrd_pkg::*;

    localparam logic [4:0] FLD_THREAD = 5'd1;
    localparam logic [4:0] FLD_USER   = 5'd2;
    localparam logic [4:0] FLD_SCHEMA = 5'd3;
    localparam logic [4:0] FLD_CLIENT = 5'd4;
    localparam logic [4:0] FLD_SERVER = 5'd6;
    localparam logic [4:0] FLD_STMT   = 5'd9;
    localparam logic [4:0] FLD_DIGEST = 5'd13;
    localparam logic [7:0] LENC_BAD   = 8'hff;
    localparam int LIMIT_CYCLES = 400000;
    localparam int HOLD_AT = 60;
    localparam int HOLD_LEN = 300;

    typedef struct packed {
        logic [4:0]  field;
        kind_t       kind;
        logic [63:0] value;
        logic [7:0]  pidx;
        logic        last;
        logic        rec_end;
    } token_t;

    logic clk;
    logic rst_n;
    elrd_in_if  in_if ();
    elrd_out_if out_if ();

    event_log_record_decoder uut (
        .clk   (clk),
        .rst_n (rst_n),
        .stream(in_if),
        .token (out_if)
    );

    logic [7:0] byte_q[$];
    token_t     token_q[$];
    logic       in_taken;
    int         cycles;
    int         bytes_in;
    int         hold_left;
    int         errors;
    bit         hold_done;

    // decoder model state
    logic [4:0]  m_phase;
    int          m_skip;
    logic [1:0]  m_cls;
    int          m_ibytes;
    int          m_ipos;
    logic [63:0] m_acc;
    logic [63:0] m_sleft;
    bit          m_host;
    int          m_ptotal;
    int          m_pdone;
    int          m_bmleft;
    bit          m_nulls[256];
    bit          m_halt;
    bit          m_instr;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic bit calm();
        return bytes_in >= 200 && bytes_in < 320;
    endfunction

    function automatic bit string_field(logic [4:0] f);
        return f == FLD_USER || f == FLD_SCHEMA || f == FLD_CLIENT || f == FLD_SERVER
            || f == FLD_QUERY || f == FLD_PARAM_VALUE;
    endfunction

    task automatic emit(logic [4:0] f, kind_t k, logic [63:0] v, logic [7:0] p,
                        logic l, logic e);
        token_t t;
        t.field = f;
        t.kind = k;
        t.value = v;
        t.pidx = p;
        t.last = l;
        t.rec_end = e;
        token_q.insert(token_q.size(), t);
    endtask

    task automatic put_byte(logic [7:0] x);
        byte_q.insert(byte_q.size(), x);
    endtask

    function automatic bit close_record();
        m_phase = PH_SKIP;
        m_skip = 8;
        m_instr = 0;
        m_ibytes = 0;
        m_ipos = 0;
        return 1'b1;
    endfunction

    function automatic bit next_param();
        m_pdone++;
        if (m_pdone >= m_ptotal)
            return close_record();
        m_phase = FLD_PARAM_VALUE;
        m_ipos = 0;
        return 1'b0;
    endfunction

    function automatic bit step_field(logic [4:0] f);
        case (f)
            FLD_HOST:
            begin
                m_phase = m_host ? 5'd7 : 5'd8;
                return 1'b0;
            end
            FLD_END:
            begin
                m_phase = (m_cls == CLS_EXECUTE || m_cls == CLS_PREPARE) ? 5'd10 : 5'd11;
                return 1'b0;
            end
            FLD_QUERY:
            begin
                if (m_cls == CLS_EXECUTE)
                begin
                    m_phase = 5'd16;
                    return 1'b0;
                end
                return close_record();
            end
            FLD_PARAM_COUNT:
            begin
                if (m_ptotal == 0)
                    return close_record();
                m_bmleft = (m_ptotal + 7) / 8;
                m_pdone = 0;
                m_phase = PH_BITMAP;
                return 1'b0;
            end
            FLD_PARAM_TYPE:
            begin
                m_phase = 5'd18;
                return 1'b0;
            end
            FLD_PARAM_VALUE:
                return next_param();
            default:
            begin
                m_phase = f + 5'd2;
                return 1'b0;
            end
        endcase
    endfunction

    function automatic bit is_null(int idx);
        return idx < 256 && m_nulls[idx];
    endfunction

    task automatic decode_byte(logic [7:0] b);
        logic [4:0]  f;
        logic [7:0]  pidx;
        logic [63:0] v;
        bit          e;
        bit          l;
        int          base;
        if (m_halt)
            return;
        if (m_phase == PH_SKIP)
        begin
            if (m_skip > 0)
                m_skip--;
            if (m_skip == 0)
                m_phase = PH_TYPE;
            return;
        end
        if (m_phase == PH_TYPE)
        begin
            m_cls = (b == TYPE_EXECUTE) ? CLS_EXECUTE : (b == TYPE_PREPARE) ? CLS_PREPARE :
                    (b == TYPE_METADATA) ? CLS_METADATA : CLS_QUERY;
            m_host = 0;
            m_ptotal = 0;
            m_pdone = 0;
            m_instr = 0;
            m_ibytes = 0;
            m_ipos = 0;
            m_phase = 5'd2;
            emit(FLD_CLASS, KIND_INT, 64'(m_cls), 8'd0, 1'b0, 1'b0);
            return;
        end
        if (m_phase == PH_BITMAP)
        begin
            base = ((m_ptotal + 7) / 8 - m_bmleft) * 8;
            for (int k = 0; k < 8; k++)
                if (base + k < m_ptotal && base + k < 256)
                    m_nulls[base + k] = b[k];
            if (m_bmleft > 0)
                m_bmleft--;
            if (m_bmleft == 0)
            begin
                m_pdone = 0;
                m_phase = FLD_PARAM_VALUE;
                m_ipos = 0;
            end
            return;
        end
        f = m_phase - 5'd1;
        if (f < FLD_THREAD || f > FLD_PARAM_VALUE)
        begin
            void'(close_record());
            return;
        end
        pidx = (f >= FLD_PARAM_TYPE) ? m_pdone[7:0] : 8'd0;
        if (f == FLD_PARAM_TYPE)
        begin
            if (m_ipos == 0)
            begin
                m_acc = 64'(b);
                m_ipos = 1;
                if (is_null(m_pdone))
                    emit(FLD_PARAM_VALUE, KIND_NULL, 64'd0, pidx, 1'b0, 1'b0);
                return;
            end
            v = m_acc | (64'(b) << 8);
            m_ipos = 0;
            e = is_null(m_pdone) ? next_param() : step_field(FLD_PARAM_TYPE);
            emit(FLD_PARAM_TYPE, KIND_INT, v, pidx, 1'b0, e);
            return;
        end
        if (m_instr)
        begin
            m_sleft--;
            l = (m_sleft == 0);
            e = 0;
            if (l)
            begin
                m_instr = 0;
                e = step_field(f);
            end
            emit(f, KIND_STR_BYTE, 64'(b), pidx, l, e);
            return;
        end
        if (m_ibytes == 0)
        begin
            if (b < LENC_MIN)
                v = 64'(b);
            else if (b == LENC_2 || b == LENC_3 || b == LENC_8)
            begin
                m_ibytes = (b == LENC_2) ? 2 : (b == LENC_3) ? 3 : 8;
                m_acc = '0;
                m_ipos = 0;
                return;
            end
            else
            begin
                m_halt = 1;
                emit(f, KIND_ERR, 64'(b), pidx, 1'b0, 1'b1);
                return;
            end
        end
        else
        begin
            m_acc |= 64'(b) << (8 * (m_ipos & 7));
            m_ipos = (m_ipos + 1) & 7;
            m_ibytes--;
            if (m_ibytes != 0)
                return;
            v = m_acc;
            m_ipos = 0;
        end
        if (string_field(f))
        begin
            if (v == 0)
                e = step_field(f);
            else
            begin
                m_instr = 1;
                m_sleft = v;
                e = 0;
            end
            emit(f, KIND_STR_LEN, v, pidx, 1'b0, e);
            return;
        end
        if (f == FLD_HOST)
            m_host = (v != '1);
        if (f == FLD_PARAM_COUNT)
        begin
            if (v > 64'd256)
            begin
                m_halt = 1;
                emit(FLD_PARAM_COUNT, KIND_ERR, v, 8'd0, 1'b0, 1'b1);
                return;
            end
            m_ptotal = int'(v);
        end
        e = step_field(f);
        emit(f, KIND_INT, v, pidx, 1'b0, e);
    endtask

    // stimulus helpers
    task automatic put_int(logic [63:0] v);
        int w;
        if (v < 251)
            w = 0;
        else if (v < 64'h1_0000)
            w = 2;
        else if (v < 64'h100_0000)
            w = 3;
        else
            w = 8;
        if (w != 8 && $urandom_range(3) == 0)
            w = (w == 0) ? 2 : (w == 2) ? 3 : 8;
        if (w == 0)
        begin
            put_byte(v[7:0]);
            return;
        end
        put_byte(w == 2 ? LENC_2 : w == 3 ? LENC_3 : LENC_8);
        for (int i = 0; i < w; i++)
            put_byte(v[8 * i +: 8]);
    endtask

    function automatic logic [63:0] rand_val();
        case ($urandom_range(6))
            0: return '0;
            1: return 64'($urandom_range(250));
            2: return 64'($urandom_range(65535, 251));
            3: return 64'($urandom_range(24'hffffff, 65536));
            4: return {$urandom, $urandom};
            5: return '1;
            default: return 64'($urandom_range(20));
        endcase
    endfunction

    task automatic put_str(int len);
        put_int(64'(len));
        for (int i = 0; i < len; i++)
            put_byte(8'($urandom));
    endtask

    function automatic int rand_len();
        return $urandom_range(5);
    endfunction

    task automatic put_record(logic [1:0] cls, int nparams, bit all_null);
        logic [63:0] host;
        logic [7:0]  tb;
        logic [7:0]  bm;
        bit          nul[$];
        for (int i = 0; i < 8; i++)
            put_byte(8'($urandom));
        case (cls)
            CLS_EXECUTE:  tb = TYPE_EXECUTE;
            CLS_PREPARE:  tb = TYPE_PREPARE;
            CLS_METADATA: tb = TYPE_METADATA;
            default:
            begin
                tb = 8'($urandom);
                while (tb >= TYPE_EXECUTE && tb <= TYPE_METADATA)
                    tb = 8'($urandom);
            end
        endcase
        put_byte(tb);
        put_int(rand_val());
        put_str(rand_len());
        put_str(rand_len());
        put_str(rand_len());
        host = ($urandom_range(2) == 0) ? '1 : rand_val();
        put_int(host);
        if (host != '1)
            put_str(rand_len());
        put_int(rand_val());
        put_int(rand_val());
        if (cls == CLS_EXECUTE || cls == CLS_PREPARE)
            put_int(rand_val());
        for (int i = FLD_STMT + 1; i <= FLD_DIGEST; i++)
            put_int(rand_val());
        put_str(rand_len());
        if (cls != CLS_EXECUTE)
            return;
        put_int(64'(nparams));
        if (nparams > MAX_PARAMS_DEF)
            return;
        for (int i = 0; i < (nparams + 7) / 8; i++)
        begin
            bm = all_null ? 8'hff : 8'($urandom);
            put_byte(bm);
            for (int k = 0; k < 8; k++)
                nul.insert(nul.size(), bm[k]);
        end
        for (int i = 0; i < nparams; i++)
        begin
            put_byte(8'($urandom));
            put_byte(8'($urandom));
            if (!nul[i])
                put_str(rand_len() % 8);
        end
    endtask

    // input driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_taken <= 1'b0;
        else
        begin
            in_taken <= in_if.valid && in_if.ready;
            if (in_if.valid && in_if.ready)
            begin
                decode_byte(in_if.data_byte);
                bytes_in <= bytes_in + 1;
            end
        end
    end

    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            in_if.valid <= 1'b0;
            in_if.data_byte <= '0;
        end
        else if (!in_if.valid || in_taken)
        begin
            if (byte_q.size() > 0 && (calm() || $urandom_range(99) >= 21))
            begin
                in_if.valid <= 1'b1;
                in_if.data_byte <= byte_q.pop_front();
            end
            else
                in_if.valid <= 1'b0;
        end
    end

    // long output stall
    always @(posedge clk)
    begin
        if (!hold_done && bytes_in >= HOLD_AT)
        begin
            hold_done <= 1'b1;
            hold_left <= HOLD_LEN;
        end
        else if (hold_left > 0)
            hold_left <= hold_left - 1;
    end

    always @(negedge clk)
    begin
        if (!rst_n)
            out_if.ready <= 1'b0;
        else
            out_if.ready <= hold_left == 0 && (calm() || $urandom_range(99) >= 21);
    end

    // token monitor
    always @(posedge clk)
    begin
        token_t want;
        if (rst_n && out_if.valid && out_if.ready)
        begin
            if (token_q.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected token f=%0d k=%0d v=%h", out_if.field_code,
                             out_if.token_kind, out_if.token_value);
            end
            else
            begin
                want = token_q.pop_front();
                if (out_if.field_code !== want.field || out_if.token_kind !== want.kind
                    || out_if.token_value !== want.value || out_if.param_index !== want.pidx
                    || out_if.string_last !== want.last || out_if.record_end !== want.rec_end)
                begin
                    errors++;
                    if (errors <= 10)
                    begin
                        $display("token mismatch: exp f=%0d k=%0d v=%h p=%0d l=%b e=%b",
                                 want.field, want.kind, want.value, want.pidx, want.last,
                                 want.rec_end);
                        $display("                got f=%0d k=%0d v=%h p=%0d l=%b e=%b",
                                 out_if.field_code, out_if.token_kind, out_if.token_value,
                                 out_if.param_index, out_if.string_last, out_if.record_end);
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES)
        begin
            $display("tb_event_log_record_decoder: done, errors");
            $finish;
        end
    end

    initial
    begin
        cycles = 0;
        bytes_in = 0;
        hold_left = 0;
        hold_done = 0;
        errors = 0;
        m_halt = 0;
        m_cls = CLS_QUERY;
        m_acc = '0;
        m_sleft = '0;
        m_host = 0;
        m_ptotal = 0;
        m_pdone = 0;
        m_bmleft = 0;
        void'(close_record());
        foreach (m_nulls[i])
            m_nulls[i] = 0;
        in_if.valid = 1'b0;
        in_if.data_byte = '0;
        out_if.ready = 1'b0;
        rst_n = 1'b0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        put_record(CLS_QUERY, 0, 0);
        put_record(CLS_EXECUTE, 3, 0);
        wait (byte_q.size() == 0 && !in_if.valid && token_q.size() == 0);

        put_record(CLS_PREPARE, 0, 0);
        put_record(CLS_METADATA, 0, 0);
        put_record(CLS_EXECUTE, 0, 0);
        put_record(CLS_EXECUTE, 9, 1);

        if ($urandom_range(1) == 0)
            put_record(CLS_EXECUTE, $urandom_range(300, MAX_PARAMS_DEF + 1), 0);
        else
        begin
            for (int i = 0; i < 8; i++)
                put_byte(8'($urandom));
            put_byte(8'($urandom));
            put_byte($urandom_range(1) ? LENC_BAD : LENC_MIN);
        end
        for (int i = 0; i < 20; i++)
            put_byte(8'($urandom));

        wait (byte_q.size() == 0 && !in_if.valid && token_q.size() == 0);
        repeat (20) @(posedge clk);
        if (errors == 0 && token_q.size() == 0)
            $display("tb_event_log_record_decoder: done, clean");
        else
            $display("tb_event_log_record_decoder: done, errors");
        $finish;
    end
endmodule
